// ===== sv/set_assoc_cache_with_prefetch_unit_defines.svh =====
// Assertion macros for the set-associative cache unit.
`ifndef SET_ASSOC_CACHE_WITH_PREFETCH_UNIT_DEFINES_SVH
`define SET_ASSOC_CACHE_WITH_PREFETCH_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SAC_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SAC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

// ===== sv/sac_pkg.sv =====
// Shared constants and types for the set-associative cache unit.
package sac_pkg;
    localparam int MAX_SETS_LOG2 = 10;
    localparam int MAX_WAYS = 8;
    localparam int ADDR_WIDTH = 48;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SET_W = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1;
    localparam int LINES = (1 << MAX_SETS_LOG2) * MAX_WAYS;
    localparam int LINE_W = $clog2(LINES);
    localparam int CNT_W = 32;
    localparam int CFG_W = 4;
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_LINE_LOG2 = 3'd0;
    localparam logic [IDX_W-1:0] REG_SETS_LOG2 = 3'd1;
    localparam logic [IDX_W-1:0] REG_WAYS = 3'd2;
    localparam logic [IDX_W-1:0] REG_USE_LRU = 3'd3;
    localparam logic [IDX_W-1:0] REG_PREFETCH = 3'd4;
    localparam int ENT_W = 1 + ADDR_WIDTH + CNT_W;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] tag;
        logic [SET_W-1:0] set;
        logic is_write;
    } req_t;

    typedef struct packed {
        logic [3:0] line_log2;
        logic [3:0] slog;
        logic [WAY_W:0] ways;
        logic use_lru;
        logic prefetch_on;
    } cfg_t;
endpackage

// ===== sv/sac_ram.sv =====
// Generic single-port RAM with registered read.
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sv/sac_front.sv =====
// Front end: config registers, address split, request queue.
module sac_front (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [sac_pkg::IDX_W-1:0] cfg_index,
    input  logic [sac_pkg::CFG_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic [sac_pkg::ADDR_WIDTH-1:0] access_address,
    input  logic is_write,
    output sac_pkg::cfg_t cfg,
    output logic q_valid,
    input  logic q_pop,
    output sac_pkg::req_t q_dem,
    output sac_pkg::req_t q_pf
);
    import sac_pkg::*;
    logic [3:0] line_reg, slog_reg, ways_reg;
    logic lru_reg, pf_reg;
    req_t d_reg [2];
    req_t p_reg [2];
    logic [1:0] cnt_reg;
    logic wp_reg, rp_reg;
    logic [3:0] slog;
    logic [ADDR_WIDTH-1:0] pa, blk, pblk;
    req_t dn, pn;
    logic push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= 4'd5;
            slog_reg <= 4'd4;
            ways_reg <= 4'd2;
            lru_reg <= 1'b1;
            pf_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LINE_LOG2: line_reg <= cfg_data;
                REG_SETS_LOG2: slog_reg <= cfg_data;
                REG_WAYS:      ways_reg <= cfg_data;
                REG_USE_LRU:   lru_reg <= cfg_data[0];
                REG_PREFETCH:  pf_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        slog = (slog_reg > 4'(MAX_SETS_LOG2)) ? 4'(MAX_SETS_LOG2) : slog_reg;
        cfg.line_log2 = line_reg;
        cfg.slog = slog;
        if (ways_reg == 4'd0)
            cfg.ways = (WAY_W+1)'(1);
        else if (ways_reg > 4'(MAX_WAYS))
            cfg.ways = (WAY_W+1)'(MAX_WAYS);
        else
            cfg.ways = (WAY_W+1)'(ways_reg);
        cfg.use_lru = lru_reg;
        cfg.prefetch_on = pf_reg;
        pa = access_address + (ADDR_WIDTH'(1) << line_reg);
        blk = access_address >> line_reg;
        pblk = pa >> line_reg;
        dn.tag = blk >> slog;
        dn.set = SET_W'(blk & ((ADDR_WIDTH'(1) << slog) - 1'b1));
        dn.is_write = is_write;
        pn.tag = pblk >> slog;
        pn.set = SET_W'(pblk & ((ADDR_WIDTH'(1) << slog) - 1'b1));
        pn.is_write = 1'b0;
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_dem = d_reg[rp_reg];
    assign q_pf = p_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            d_reg[wp_reg] <= dn;
            p_reg[wp_reg] <= pn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (q_pop && q_valid)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end
endmodule

// ===== sv/sac_back.sv =====
// Back end: way-serial tag lookup, fill, counters, result register.
module sac_back (
    input  logic clk,
    input  logic rst_n,
    input  sac_pkg::cfg_t cfg,
    input  logic q_valid,
    output logic q_pop,
    input  sac_pkg::req_t q_dem,
    input  sac_pkg::req_t q_pf,
    output logic out_valid,
    input  logic out_stall,
    output logic demand_hit,
    output logic demand_evicted,
    output logic prefetch_fill,
    output logic [31:0] reads_total,
    output logic [31:0] writes_total,
    output logic [31:0] hits_total,
    output logic [31:0] misses_total
);
    import sac_pkg::*;
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLR   = 6'b000010,
        S_RD    = 6'b000100,
        S_CHK   = 6'b001000,
        S_WR    = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;
    state_t st_reg, st_next;
    logic [SET_W-1:0] clr_reg;
    logic [WAY_W:0] w_reg;
    logic pf_reg;
    logic found_reg, empty_reg;
    logic [WAY_W-1:0] fw_reg, ew_reg, vw_reg;
    logic [CNT_W-1:0] vs_reg;
    logic [CNT_W-1:0] stamp_reg, rd_reg, wr_reg, hit_reg, miss_reg;
    logic dh_reg, dev_reg, pff_reg;
    logic [MAX_WAYS-1:0] vbits;
    logic [MAX_WAYS-1:0] vrow_q;
    logic [ENT_W-1:0] rdata;
    logic [ENT_W-1:0] wdata;
    logic we, vwe;
    logic [LINE_W-1:0] addr;
    logic [MAX_WAYS-1:0] vwdata;
    req_t cur;
    logic ent_hit;
    logic [WAY_W-1:0] w_idx;
    logic [SET_W-1:0] vaddr;

    function automatic logic [CNT_W-1:0] sat(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    assign cur = pf_reg ? q_pf : q_dem;
    assign w_idx = w_reg[WAY_W-1:0];
    assign vaddr = (st_reg == S_CLR) ? clr_reg : cur.set;

    // valid-bit rows, one word per set; cleared by sweep after reset
    sac_ram #(.WIDTH(MAX_WAYS), .DEPTH(1 << SET_W)) u_valid (
        .clk(clk), .we(vwe), .addr(vaddr), .wdata(vwdata), .rdata(vrow_q)
    );
    sac_ram #(.WIDTH(ENT_W), .DEPTH(LINES)) u_tag (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign vbits = vrow_q;
    assign ent_hit = vbits[w_idx] && (rdata[ADDR_WIDTH+CNT_W-1:CNT_W] == cur.tag);

    always_comb
    begin
        st_next = st_reg;
        we = 1'b0;
        vwe = 1'b0;
        vwdata = vbits;
        wdata = {1'b1, cur.tag, stamp_reg};
        addr = LINE_W'({cur.set, w_idx});
        q_pop = 1'b0;
        unique case (st_reg)
            S_CLR:
            begin
                vwe = 1'b1;
                vwdata = '0;
                if (clr_reg == '1)
                    st_next = S_IDLE;
            end
            S_IDLE:
                if (q_valid)
                    st_next = S_RD;
            S_RD:
                st_next = S_CHK;
            S_CHK:
                if (w_reg == cfg.ways - 1'b1 || (ent_hit && !found_reg))
                    st_next = S_WR;
                else
                    st_next = S_RD;
            S_WR:
            begin
                if (found_reg)
                begin
                    addr = LINE_W'({cur.set, fw_reg});
                    we = !pf_reg && cfg.use_lru;
                    wdata = {1'b1, rdata[ADDR_WIDTH+CNT_W-1:CNT_W], stamp_reg};
                    wdata[ADDR_WIDTH+CNT_W-1:CNT_W] = cur.tag;
                end
                else
                begin
                    addr = LINE_W'({cur.set, (empty_reg ? ew_reg : vw_reg)});
                    we = 1'b1;
                    vwe = 1'b1;
                    vwdata[empty_reg ? ew_reg : vw_reg] = 1'b1;
                end
                if (!pf_reg && !found_reg && cfg.prefetch_on)
                    st_next = S_RD;
                else
                    st_next = S_OUT;
            end
            S_OUT:
                if (!out_valid || !out_stall)
                begin
                    q_pop = 1'b1;
                    st_next = S_IDLE;
                end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLR;
            clr_reg <= '0;
            w_reg <= '0;
            pf_reg <= 1'b0;
            found_reg <= 1'b0;
            empty_reg <= 1'b0;
            stamp_reg <= '0;
            rd_reg <= '0;
            wr_reg <= '0;
            hit_reg <= '0;
            miss_reg <= '0;
            dh_reg <= 1'b0;
            dev_reg <= 1'b0;
            pff_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            unique case (st_reg)
                S_CLR:
                    clr_reg <= clr_reg + 1'b1;
                S_IDLE:
                    if (q_valid)
                    begin
                        w_reg <= '0;
                        pf_reg <= 1'b0;
                        found_reg <= 1'b0;
                        empty_reg <= 1'b0;
                        stamp_reg <= stamp_reg + 1'b1;
                        if (q_dem.is_write)
                            wr_reg <= sat(wr_reg);
                    end
                S_RD: ;
                S_CHK:
                begin
                    if (ent_hit && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        fw_reg <= w_idx;
                    end
                    if (!vbits[w_idx] && !empty_reg)
                    begin
                        empty_reg <= 1'b1;
                        ew_reg <= w_idx;
                    end
                    if (w_reg == '0 || rdata[CNT_W-1:0] < vs_reg)
                    begin
                        vs_reg <= rdata[CNT_W-1:0];
                        vw_reg <= w_idx;
                    end
                    w_reg <= w_reg + 1'b1;
                end
                S_WR:
                begin
                    if (!pf_reg)
                    begin
                        dh_reg <= found_reg;
                        dev_reg <= !found_reg && !empty_reg;
                        pff_reg <= 1'b0;
                        if (found_reg)
                            hit_reg <= sat(hit_reg);
                        else
                        begin
                            miss_reg <= sat(miss_reg);
                            rd_reg <= sat(rd_reg);
                        end
                        if (!found_reg && cfg.prefetch_on)
                        begin
                            pf_reg <= 1'b1;
                            w_reg <= '0;
                            found_reg <= 1'b0;
                            empty_reg <= 1'b0;
                            stamp_reg <= stamp_reg + 1'b1;
                        end
                    end
                    else if (!found_reg)
                    begin
                        pff_reg <= 1'b1;
                        rd_reg <= sat(rd_reg);
                    end
                end
                S_OUT:
                    if (!out_valid || !out_stall)
                    begin
                        out_valid <= 1'b1;
                        demand_hit <= dh_reg;
                        demand_evicted <= dev_reg;
                        prefetch_fill <= pff_reg;
                        reads_total <= rd_reg;
                        writes_total <= wr_reg;
                        hits_total <= hit_reg;
                        misses_total <= miss_reg;
                    end
                default: ;
            endcase
        end
    end
endmodule

// ===== sv/set_assoc_cache_with_prefetch_unit.sv =====
// Top level of the set-associative tag cache with next-line prefetch.
// Each access is looked up way by way (a tag read, then a check per way), ending early
// on a hit, then filled or updated; a demand miss with prefetch on also looks up and
// fills the next line. One access is processed at a time, and an output stall holds it.
// Reset: async active low; then a sweep clears the valid row of every set before the
// first access is processed (config writes still taken).
module set_assoc_cache_with_prefetch_unit (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [3:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic [47:0] access_address,
    input  logic is_write,
    output logic out_valid,
    input  logic out_stall,
    output logic demand_hit,
    output logic demand_evicted,
    output logic prefetch_fill,
    output logic [31:0] reads_total,
    output logic [31:0] writes_total,
    output logic [31:0] hits_total,
    output logic [31:0] misses_total
);
    import sac_pkg::*;
    cfg_t cfg;
    logic q_valid, q_pop;
    req_t q_dem, q_pf;

    // front: config, address split, two-entry transfer queue
    sac_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .access_address(access_address), .is_write(is_write), .cfg(cfg),
        .q_valid(q_valid), .q_pop(q_pop), .q_dem(q_dem), .q_pf(q_pf)
    );

    // back: way-serial lookup and fill, counters, result register
    sac_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_valid(q_valid), .q_pop(q_pop),
        .q_dem(q_dem), .q_pf(q_pf), .out_valid(out_valid), .out_stall(out_stall),
        .demand_hit(demand_hit), .demand_evicted(demand_evicted),
        .prefetch_fill(prefetch_fill), .reads_total(reads_total),
        .writes_total(writes_total), .hits_total(hits_total),
        .misses_total(misses_total)
    );
endmodule

// ===== sv/sac_checker.sv =====
// Port-level checker for the cache unit and its bind.
`include "set_assoc_cache_with_prefetch_unit_defines.svh"
module sac_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic demand_hit,
    input logic demand_evicted,
    input logic prefetch_fill,
    input logic [31:0] hits_total
);
    `SAC_ASSERT_IMPL(a_hit_no_evict, clk, rst_n, out_valid && demand_hit, !demand_evicted)
    `SAC_ASSERT_IMPL(a_hit_no_pf, clk, rst_n, out_valid && demand_hit, !prefetch_fill)
    `SAC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(hits_total))
endmodule

bind set_assoc_cache_with_prefetch_unit sac_checker u_sac_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .demand_hit(demand_hit), .demand_evicted(demand_evicted),
    .prefetch_fill(prefetch_fill), .hits_total(hits_total)
);
